>>> sv/lcc_pkg.sv
package lcc_pkg;

   // card number and result field widths
   localparam int CARD_W = 64;
   localparam int COUNT_W = 5;
   localparam int CLASS_W = 2;

   // binary to decimal conversion: bits shifted in per cycle and number of conversion steps
   localparam int DAB_BITS = 8;
   localparam int DAB_STEPS = CARD_W / DAB_BITS;
   localparam int STEP_W = $clog2(DAB_STEPS);

   // class codes
   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_FOUR = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_THREE = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_FIVE = 2'd3;

   // ten to the n-th power, evaluated at elaboration only
   function automatic logic [CARD_W-1:0] pow10(input int n);
      logic [CARD_W-1:0] p;
      p = CARD_W'(1);
      for (int i = 0; i < 19; i++) begin
         if (i < n) begin
            p = p * CARD_W'(10);
         end
      end
      return p;
   endfunction

   // doubled digit folded to the sum of its decimal digits
   function automatic logic [3:0] luhn_double(input logic [3:0] d);
      logic [4:0] k;
      k = {d, 1'b0};
      if (d >= 4'd5) begin
         k = k - 5'd9;
      end
      return k[3:0];
   endfunction

endpackage

>>> sv/lcc_dabble.sv
module lcc_dabble
   import lcc_pkg::*;
#(
   parameter int BCD_W = 76
) (
   input  logic [BCD_W-1:0]    bcd_cur,
   input  logic [DAB_BITS-1:0] bits_cur,
   output logic [BCD_W-1:0]    bcd_nxt
);

   localparam int NDIG = BCD_W / 4;

   logic [BCD_W-1:0] work;

   // shift-add-3 over every decimal digit, one input bit per step
   always_comb begin
      work = bcd_cur;
      for (int s = 0; s < DAB_BITS; s++) begin
         for (int g = 0; g < NDIG; g++) begin
            if (work[4*g +: 4] >= 4'd5) begin
               work[4*g +: 4] = work[4*g +: 4] + 4'd3;
            end
         end
         work = {work[BCD_W-2:0], bits_cur[DAB_BITS-1-s]};
      end
      bcd_nxt = work;
   end

endmodule

>>> sv/luhn_card_number_classifier.sv
// Luhn card number classifier.
// Request channel: req_valid / req_stall carry one 64-bit binary card number
// (req_card_number). A transfer happens when req_valid is high and req_stall
// is low. Response channel: rsp_valid / rsp_stall carry checksum flag, decimal
// digit count and class code, one response per request, in order.
// Operation: after the request transfer the number is converted to decimal,
// 8 bits per cycle through the shift-add-3 unit, then the digits
// are scanned one per cycle from the least significant end until no nonzero
// digit remains, then the DONE state loads the response register; a number
// of 10^MAX_DIGITS or more skips straight to the response (zeros).
// One number is worked on at a time; req_stall is high while busy.
// The next request is taken while the previous response waits in its
// register. If rsp_stall holds the response, a finished number waits in
// its last state and the block accepts nothing more until the hold clears.
// Reset (synchronous, active high) drops any number in progress and any
// pending response; the block is ready in the next cycle.
module luhn_card_number_classifier
   import lcc_pkg::*;
#(
   parameter int MAX_DIGITS = 19
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CARD_W-1:0]  req_card_number,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_checksum_ok,
   output logic [COUNT_W-1:0] rsp_digit_count,
   output logic [CLASS_W-1:0] rsp_card_class
);

   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam logic [CARD_W-1:0] DIGIT_LIMIT = pow10(MAX_DIGITS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DAB_STEPS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CARD_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [3:0]         total_ff, total_in;
   logic [3:0]         lead_hi_ff, lead_hi_in;
   logic [3:0]         lead_lo_ff, lead_lo_in;
   logic               over_ff, over_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               ok_ff, ok_in;
   logic [COUNT_W-1:0] cnt_out_ff, cnt_out_in;
   logic [CLASS_W-1:0] cls_ff, cls_in;

   logic [BCD_W-1:0]   dab_out;
   logic [3:0]         digit;
   logic [3:0]         addend;
   logic [4:0]         sum;
   logic               sum_ok;
   logic [CLASS_W-1:0] cls_calc;

   // single conversion unit, reused on every conversion step
   lcc_dabble #(
      .BCD_W(BCD_W)
   ) u_dabble (
      .bcd_cur (bcd_ff),
      .bits_cur(bin_ff[CARD_W-1 -: DAB_BITS]),
      .bcd_nxt (dab_out)
   );

   // per-digit luhn contribution, running total kept modulo ten
   always_comb begin
      digit = bcd_ff[3:0];
      addend = count_ff[0] ? luhn_double(digit) : digit;
      sum = {1'b0, total_ff} + {1'b0, addend};
      if (sum >= 5'd10) begin
         sum = sum - 5'd10;
      end
   end

   // class from leading digits and length, only when the checksum holds
   always_comb begin
      sum_ok = (total_ff == 4'd0) && !over_ff;
      cls_calc = CLASS_NONE;
      if (sum_ok) begin
         priority if (lead_hi_ff == 4'd4 &&
                      (count_ff == COUNT_W'(13) || count_ff == COUNT_W'(16))) begin
            cls_calc = CLASS_FOUR;
         end else if (lead_hi_ff == 4'd3 && (lead_lo_ff == 4'd4 || lead_lo_ff == 4'd7) &&
                      count_ff == COUNT_W'(15)) begin
            cls_calc = CLASS_THREE;
         end else if (lead_hi_ff == 4'd5 && lead_lo_ff >= 4'd1 && lead_lo_ff <= 4'd5 &&
                      count_ff == COUNT_W'(16)) begin
            cls_calc = CLASS_FIVE;
         end else begin
            cls_calc = CLASS_NONE;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      step_in = step_ff;
      count_in = count_ff;
      total_in = total_ff;
      lead_hi_in = lead_hi_ff;
      lead_lo_in = lead_lo_ff;
      over_in = over_ff;
      rsp_valid_in = rsp_valid_ff;
      ok_in = ok_ff;
      cnt_out_in = cnt_out_ff;
      cls_in = cls_ff;

      // response taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bin_in = req_card_number;
               bcd_in = '0;
               step_in = '0;
               count_in = '0;
               total_in = '0;
               lead_hi_in = '0;
               lead_lo_in = '0;
               over_in = (req_card_number >= DIGIT_LIMIT);
               state_in = (req_card_number >= DIGIT_LIMIT) ? ST_DONE : ST_CONV;
            end
         end
         ST_CONV: begin
            bin_in = bin_ff << DAB_BITS;
            bcd_in = dab_out;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (bcd_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               total_in = sum[3:0];
               lead_hi_in = digit;
               lead_lo_in = lead_hi_ff;
               count_in = count_ff + COUNT_W'(1);
               bcd_in = bcd_ff >> 4;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               ok_in = sum_ok;
               cnt_out_in = over_ff ? '0 : count_ff;
               cls_in = cls_calc;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and response payload
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      step_ff <= step_in;
      count_ff <= count_in;
      total_ff <= total_in;
      lead_hi_ff <= lead_hi_in;
      lead_lo_ff <= lead_lo_in;
      over_ff <= over_in;
      ok_ff <= ok_in;
      cnt_out_ff <= cnt_out_in;
      cls_ff <= cls_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_checksum_ok = ok_ff;
   assign rsp_digit_count = cnt_out_ff;
   assign rsp_card_class = cls_ff;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb
   import lcc_pkg::*;
();

   localparam logic [CARD_W-1:0] CARD_LIMIT = 64'd10000000000000000000;
   localparam logic [CARD_W-1:0] CARD_MAX = 64'd9999999999999999999;
   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] count;
      logic [CLASS_W-1:0] cls;
   } luhn_verdict_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [CARD_W-1:0]  req_card_number;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_checksum_ok;
   logic [COUNT_W-1:0] rsp_digit_count;
   logic [CLASS_W-1:0] rsp_card_class;

   luhn_verdict_type pending_verdicts[$];
   int req_idle_pct;
   int rsp_hold_pct;
   int mismatch_count;
   int cards_sent;
   int cards_luhn_ok;
   int cards_too_long;
   int verdicts_checked;

   luhn_card_number_classifier u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_card_number (req_card_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_digit_count (rsp_digit_count),
      .rsp_card_class  (rsp_card_class)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // luhn check, digit count and class of one card number
   function automatic luhn_verdict_type luhn_verdict(input logic [CARD_W-1:0] number);
      luhn_verdict_type v;
      logic [CARD_W-1:0] rest;
      logic [CARD_W-1:0] top1;
      logic [CARD_W-1:0] top2;
      int unsigned digits;
      int unsigned total;
      int unsigned d;
      int unsigned twice;
      v = '0;
      if (number >= CARD_LIMIT) begin
         return v;
      end
      rest = number;
      top1 = '0;
      top2 = '0;
      digits = 0;
      total = 0;
      // peel digits from the least significant end
      while (rest != 0) begin
         if (rest < 10) begin
            top1 = rest;
         end else if (rest < 100) begin
            top2 = rest;
         end
         d = int'(rest % 10);
         digits++;
         if (digits % 2 == 0) begin
            twice = d * 2;
            total += twice % 10 + twice / 10;
         end else begin
            total += d;
         end
         rest = rest / 10;
      end
      v.ok = (total % 10 == 0);
      v.count = COUNT_W'(digits);
      v.cls = CLASS_NONE;
      // class only when the checksum holds
      if (v.ok) begin
         if (top1 == 4 && (digits == 13 || digits == 16)) begin
            v.cls = CLASS_FOUR;
         end else if ((top2 == 34 || top2 == 37) && digits == 15) begin
            v.cls = CLASS_THREE;
         end else if (top2 >= 51 && top2 <= 55 && digits == 16) begin
            v.cls = CLASS_FIVE;
         end
      end
      return v;
   endfunction

   // number of len digits starting with lead, check digit fixed or broken
   function automatic logic [CARD_W-1:0] make_card(input int len, input int lead,
                                                   input int lead_len, input bit good);
      logic [CARD_W-1:0] value;
      logic [CARD_W-1:0] base;
      int last;
      value = CARD_W'(lead);
      for (int i = lead_len; i < len; i++) begin
         value = value * 10 + CARD_W'($urandom_range(0, 9));
      end
      if (len < 2) begin
         return value;
      end
      base = value - value % 10;
      for (int c = 0; c < 10; c++) begin
         if (luhn_verdict(base + CARD_W'(c)).ok) begin
            last = c;
         end
      end
      if (!good) begin
         last = (last + $urandom_range(1, 9)) % 10;
      end
      return base + CARD_W'(last);
   endfunction

   task automatic note_mismatch(input string what, input luhn_verdict_type want,
                                input luhn_verdict_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
         $display("%0t: %s: expected ok=%0b count=%0d class=%0d,",
                  $realtime, what, want.ok, want.count, want.cls);
         $display("   got ok=%0b count=%0d class=%0d", got.ok, got.count, got.cls);
      end
   endtask

   // one card number transfer, the sender idling on some cycles ahead of it
   task automatic send_card(input logic [CARD_W-1:0] number);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_card_number <= number;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // random hold on the response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_hold_pct);
      end
   end

   // check each response transfer, then record each request transfer
   always @(posedge clock) begin
      luhn_verdict_type want;
      luhn_verdict_type got;
      if (!reset) begin
         got.ok = rsp_checksum_ok;
         got.count = rsp_digit_count;
         got.cls = rsp_card_class;
         if (rsp_valid && !rsp_stall) begin
            verdicts_checked++;
            if (pending_verdicts.size() == 0) begin
               note_mismatch("response with nothing outstanding", '0, got);
            end else begin
               want = pending_verdicts.pop_front();
               if (got.ok !== want.ok || got.count !== want.count || got.cls !== want.cls) begin
                  note_mismatch("response mismatch", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = luhn_verdict(req_card_number);
            pending_verdicts.push_back(want);
            cards_sent++;
            if (want.ok) begin
               cards_luhn_ok++;
            end
            if (req_card_number >= CARD_LIMIT) begin
               cards_too_long++;
            end
         end
      end
   end

   // zero, single digits, widest values and the over-length rejection
   task automatic check_boundary_values();
      send_card(64'd0);
      send_card(64'd1);
      send_card(64'd4);
      send_card(64'd9);
      send_card(64'd10);
      send_card(64'd18);
      send_card(64'd1000000000000000000);
      send_card(CARD_MAX);
      send_card(CARD_LIMIT);
      send_card(64'h8000000000000000);
      send_card(64'hFFFFFFFFFFFFFFFF);
   endtask

   // every class, a failed checksum on a good prefix, and near misses
   task automatic check_class_prefixes();
      send_card(make_card(13, 4, 1, 1));
      send_card(make_card(16, 4, 1, 1));
      send_card(make_card(15, 34, 2, 1));
      send_card(make_card(15, 37, 2, 1));
      send_card(make_card(16, 51, 2, 1));
      send_card(make_card(16, 55, 2, 1));
      send_card(make_card(16, 4, 1, 0));
      send_card(make_card(15, 37, 2, 0));
      send_card(make_card(14, 4, 1, 1));
      send_card(make_card(16, 50, 2, 1));
      send_card(make_card(16, 56, 2, 1));
      send_card(make_card(15, 35, 2, 1));
      send_card(make_card(16, 34, 2, 1));
   endtask

   // mostly well-formed card numbers, the rest broken or raw noise
   task automatic run_random_cards(input int n);
      int pick;
      int shape;
      int len;
      bit good;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         good = (pick < 60);
         shape = $urandom_range(0, 5);
         if (pick >= 90) begin
            send_card({$urandom(), $urandom()});
         end else if (pick >= 75) begin
            len = $urandom_range(1, 19);
            send_card(make_card(len, $urandom_range(1, 9), 1, $urandom_range(0, 1)));
         end else begin
            case (shape)
               0: send_card(make_card(13, 4, 1, good));
               1: send_card(make_card(16, 4, 1, good));
               2: send_card(make_card(15, ($urandom_range(0, 1) ? 34 : 37), 2, good));
               3: send_card(make_card(16, $urandom_range(51, 55), 2, good));
               4: send_card(make_card($urandom_range(2, 19), $urandom_range(10, 99), 2, good));
               default: send_card(make_card($urandom_range(12, 19),
                                            ($urandom_range(0, 1) ? 34 : 52), 2, good));
            endcase
         end
      end
   endtask

   initial begin
      int guard;
      reset = 1'b1;
      req_valid = 1'b0;
      req_card_number = '0;
      req_idle_pct = 14;
      rsp_hold_pct = 56;
      mismatch_count = 0;
      cards_sent = 0;
      cards_luhn_ok = 0;
      cards_too_long = 0;
      verdicts_checked = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      check_boundary_values();
      check_class_prefixes();
      run_random_cards(180);
      req_idle_pct = 56;
      rsp_hold_pct = 14;
      run_random_cards(180);
      req_idle_pct = 0;
      rsp_hold_pct = 0;
      run_random_cards(170);
      req_valid <= 1'b0;

      // drain outstanding responses
      guard = 0;
      while (pending_verdicts.size() > 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);

      $display("sent %0d card numbers: %0d with a good checksum, %0d over nineteen digits",
               cards_sent, cards_luhn_ok, cards_too_long);
      $display("checked %0d responses under three sender/receiver idle mixes, %0d mismatches",
               verdicts_checked, mismatch_count);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("luhn_card_number_classifier verification clean");
      end else begin
         if (pending_verdicts.size() != 0) begin
            $display("%0d responses never arrived", pending_verdicts.size());
         end
         $display("luhn_card_number_classifier verification failed");
      end
      $finish;
   end

   // hard stop
   initial begin
      #5000000;
      $display("luhn_card_number_classifier verification failed");
      $finish;
   end

endmodule
